// File: rtl/core/bdslp_pkg.sv
// Package for the push-button debouncer with short and long press detection.
// Holds the payload and configuration types, register indexes and reset values.
// No dependencies.
package bdslp_pkg;

   localparam int unsigned TimeWidth = 32;
   localparam int unsigned MsWidth   = 16;
   localparam int unsigned CsrDataWidth = 32;
   localparam int unsigned CsrAddrWidth = 4;
   localparam int unsigned CsrIndexWidth = 2;

   // Register indexes (byte address divided by four).
   localparam logic [CsrIndexWidth-1:0] RegActiveLow  = 2'd0;
   localparam logic [CsrIndexWidth-1:0] RegDebounceMs = 2'd1;
   localparam logic [CsrIndexWidth-1:0] RegLongPressMs = 2'd2;

   // Values after reset.
   localparam logic               ResetActiveLow  = 1'b1;
   localparam logic [MsWidth-1:0] ResetDebounceMs = 16'd50;
   localparam logic [MsWidth-1:0] ResetLongPressMs = 16'd800;

   typedef struct packed {
      logic                 pin_level;
      logic [TimeWidth-1:0] now_ms;
   } req_word_type;

   typedef struct packed {
      logic stable_pressed;
      logic press_event;
      logic short_press;
      logic long_press;
   } rsp_word_type;

   typedef struct packed {
      logic               active_low;
      logic [MsWidth-1:0] debounce_ms;
      logic [MsWidth-1:0] long_press_ms;
   } cfg_type;

endpackage

// File: rtl/core/bdslp_csr.sv
// Configuration registers of the button debouncer, behind an APB-style port.
// Depends on bdslp_pkg.
module bdslp_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [bdslp_pkg::CsrAddrWidth-1:0]   paddr,
   input  logic [bdslp_pkg::CsrDataWidth-1:0]   pwdata,
   output logic [bdslp_pkg::CsrDataWidth-1:0]   prdata,
   output logic                                 pready,
   output bdslp_pkg::cfg_type                   cfg
);

   bdslp_pkg::cfg_type cfg_ff;
   bdslp_pkg::cfg_type cfg_in;
   logic [bdslp_pkg::CsrIndexWidth-1:0] index;
   logic write_strobe;

   assign index = paddr[bdslp_pkg::CsrAddrWidth-1:2];
   assign write_strobe = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_strobe) begin
         unique case (index)
            bdslp_pkg::RegActiveLow: begin
               cfg_in.active_low = pwdata[0];
            end
            bdslp_pkg::RegDebounceMs: begin
               cfg_in.debounce_ms = pwdata[bdslp_pkg::MsWidth-1:0];
            end
            bdslp_pkg::RegLongPressMs: begin
               cfg_in.long_press_ms = pwdata[bdslp_pkg::MsWidth-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      unique case (index)
         bdslp_pkg::RegActiveLow: begin
            prdata = {{(bdslp_pkg::CsrDataWidth-1){1'b0}}, cfg_ff.active_low};
         end
         bdslp_pkg::RegDebounceMs: begin
            prdata = {{(bdslp_pkg::CsrDataWidth-bdslp_pkg::MsWidth){1'b0}},
                      cfg_ff.debounce_ms};
         end
         bdslp_pkg::RegLongPressMs: begin
            prdata = {{(bdslp_pkg::CsrDataWidth-bdslp_pkg::MsWidth){1'b0}},
                      cfg_ff.long_press_ms};
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_low    <= bdslp_pkg::ResetActiveLow;
         cfg_ff.debounce_ms   <= bdslp_pkg::ResetDebounceMs;
         cfg_ff.long_press_ms <= bdslp_pkg::ResetLongPressMs;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: rtl/core/bdslp_core.sv
// Debounce and press classification for one poll, with the button state registers.
// Depends on bdslp_pkg.
module bdslp_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  bdslp_pkg::cfg_type        cfg,
   input  bdslp_pkg::req_word_type   poll,
   output bdslp_pkg::rsp_word_type   result
);

   logic                              stable_ff, stable_in;
   logic                              prev_raw_ff, prev_raw_in;
   logic                              long_sent_ff, long_sent_in;
   logic [bdslp_pkg::TimeWidth-1:0]   last_change_ff, last_change_in;
   logic [bdslp_pkg::TimeWidth-1:0]   press_start_ff, press_start_in;

   logic                              reading;
   logic [bdslp_pkg::TimeWidth-1:0]   since_change;
   logic [bdslp_pkg::TimeWidth-1:0]   since_old_start;
   logic [bdslp_pkg::TimeWidth-1:0]   held_time;
   logic [bdslp_pkg::TimeWidth-1:0]   debounce_wide;
   logic [bdslp_pkg::TimeWidth-1:0]   long_wide;
   logic                              settle;
   logic                              press_ev;
   logic                              short_ev;
   logic                              long_ev;
   logic                              sent_after_press;

   assign debounce_wide = {{(bdslp_pkg::TimeWidth-bdslp_pkg::MsWidth){1'b0}}, cfg.debounce_ms};
   assign long_wide = {{(bdslp_pkg::TimeWidth-bdslp_pkg::MsWidth){1'b0}}, cfg.long_press_ms};

   always_comb begin
      reading = poll.pin_level ^ cfg.active_low;
      prev_raw_in = reading;
      // A change of the reading restarts the debounce time at this poll.
      last_change_in = (reading != prev_raw_ff) ? poll.now_ms : last_change_ff;
      since_change = poll.now_ms - last_change_in;
      settle = (since_change > debounce_wide) && (reading != stable_ff);

      stable_in = settle ? reading : stable_ff;
      press_ev = settle && reading;
      since_old_start = poll.now_ms - press_start_ff;
      short_ev = settle && !reading && !long_sent_ff && (since_old_start < long_wide);

      press_start_in = press_ev ? poll.now_ms : press_start_ff;
      sent_after_press = press_ev ? 1'b0 : long_sent_ff;
      held_time = poll.now_ms - press_start_in;
      long_ev = stable_in && !sent_after_press && (held_time >= long_wide);
      long_sent_in = sent_after_press || long_ev;

      result.stable_pressed = stable_in;
      result.press_event = press_ev;
      result.short_press = short_ev;
      result.long_press = long_ev;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff      <= 1'b0;
         prev_raw_ff    <= 1'b0;
         long_sent_ff   <= 1'b0;
         last_change_ff <= '0;
         press_start_ff <= '0;
      end else if (step) begin
         stable_ff      <= stable_in;
         prev_raw_ff    <= prev_raw_in;
         long_sent_ff   <= long_sent_in;
         last_change_ff <= last_change_in;
         press_start_ff <= press_start_in;
      end
   end

endmodule

// File: rtl/core/button_debounce_short_long_press.sv
// Top level of the push-button debouncer with short and long press detection.
// Depends on bdslp_pkg, bdslp_csr and bdslp_core.
//
// Each word on the req_ channel is one poll of the button: the raw pin level
// and a free-running millisecond timestamp. For every poll the block returns
// exactly one word on the rsp_ channel with the debounced pressed state and
// the press, short-press and long-press event flags for that poll.
//
// Both channels use valid/ready. A poll is captured in an input register and
// processed by the debounce logic from there; its result is then held in the
// result register until the receiver takes it. One poll per cycle is sustained
// while the receiver takes every result; the single state update per poll in
// the debounce logic sets that rate.
//
// When the receiver stalls, the result register holds its word and the input
// register still takes one more poll; after that req_ready drops until the
// result is taken. Reset clears both registers and the button state (released, no
// long press sent, timestamps zero) and loads the defaults: active low, 50 ms
// debounce, 800 ms long press. The user writes configuration via the APB-style
// port (byte addresses 0, 4, 8) only while idle; the block does not enforce it.
module button_debounce_short_long_press (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  bdslp_pkg::req_word_type              req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output bdslp_pkg::rsp_word_type              rsp_payload,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [bdslp_pkg::CsrAddrWidth-1:0]   paddr,
   input  logic [bdslp_pkg::CsrDataWidth-1:0]   pwdata,
   output logic [bdslp_pkg::CsrDataWidth-1:0]   prdata,
   output logic                                 pready
);

   bdslp_pkg::cfg_type      cfg;
   bdslp_pkg::req_word_type poll_ff, poll_in;
   bdslp_pkg::rsp_word_type rsp_ff, rsp_in;
   bdslp_pkg::rsp_word_type step_result;
   logic                    poll_valid_ff, poll_valid_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    stage_advance;
   logic                    step;

   bdslp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   bdslp_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .cfg    (cfg),
      .poll   (poll_ff),
      .result (step_result)
   );

   // The result register can take a new word when it is empty or being drained.
   assign stage_advance = !rsp_valid_ff || rsp_ready;
   assign step = poll_valid_ff && stage_advance;
   assign req_ready = !poll_valid_ff || stage_advance;

   always_comb begin
      poll_valid_in = req_ready ? req_valid : poll_valid_ff;
      poll_in = (req_valid && req_ready) ? req_payload : poll_ff;
      rsp_valid_in = stage_advance ? poll_valid_ff : rsp_valid_ff;
      rsp_in = step ? step_result : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         poll_valid_ff <= poll_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      poll_ff <= poll_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // A press event always leaves the button in the pressed state.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_payload.press_event || rsp_payload.stable_pressed))
      else $error("press event without pressed state");

   // A short press comes only with a release, never with a long press.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.short_press |->
         !rsp_payload.stable_pressed && !rsp_payload.long_press)
      else $error("short press with pressed state or long press");

   // A long press is reported only while the button is held.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.long_press |-> rsp_payload.stable_pressed)
      else $error("long press while released");

   // An empty result register never blocks the input side.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");

   // Nothing is presented in the cycle after reset.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for button_debounce_short_long_press.
// Depends on bdslp_pkg and the RTL of the block; needs no files or arguments.
module tb;

   localparam int unsigned CycleLimit = 400000;
   localparam int unsigned ShownMismatches = 10;
   localparam int unsigned HoldOffAfter = 200;
   localparam int unsigned HoldOffCycles = 64;
   localparam int unsigned NumRows = 30;

   // The directed part is a table. A row either polls the button or writes one
   // register; the register rows wait until the block has drained first.
   typedef enum logic [1:0] {
      RowPoll, RowActiveLow, RowDebounce, RowLongPress
   } row_kind_type;

   typedef struct packed {
      row_kind_type             kind;
      logic                     pin;
      logic [31:0]              value;
      logic                     fixed;
      bdslp_pkg::rsp_word_type  want;
   } stim_row_type;

   logic                                  clock = 1'b0;
   logic                                  reset;
   logic                                  req_valid;
   logic                                  req_ready;
   bdslp_pkg::req_word_type               req_payload;
   logic                                  rsp_valid;
   logic                                  rsp_ready;
   bdslp_pkg::rsp_word_type               rsp_payload;
   logic                                  psel;
   logic                                  penable;
   logic                                  pwrite;
   logic [bdslp_pkg::CsrAddrWidth-1:0]    paddr;
   logic [bdslp_pkg::CsrDataWidth-1:0]    pwdata;
   logic [bdslp_pkg::CsrDataWidth-1:0]    prdata;
   logic                                  pready;

   // Rows with a typed-in answer: the answer travels beside the poll word and is
   // used in place of the predicted one when the word is accepted.
   logic                                  want_fixed;
   bdslp_pkg::rsp_word_type               want_word;

   // Settings as the block should hold them, and the button state it should track.
   logic                                  set_active_low = bdslp_pkg::ResetActiveLow;
   logic [bdslp_pkg::MsWidth-1:0]         set_debounce_ms = bdslp_pkg::ResetDebounceMs;
   logic [bdslp_pkg::MsWidth-1:0]         set_long_ms = bdslp_pkg::ResetLongPressMs;
   logic                                  btn_state = 1'b0;
   logic                                  btn_prev_reading = 1'b0;
   logic [bdslp_pkg::TimeWidth-1:0]       btn_change_ms = '0;
   logic [bdslp_pkg::TimeWidth-1:0]       btn_press_ms = '0;
   logic                                  btn_long_sent = 1'b0;

   bdslp_pkg::rsp_word_type               pending_flags [$];
   int unsigned                           mismatches = 0;
   int unsigned                           polls_taken = 0;
   int unsigned                           words_checked = 0;
   int unsigned                           presses = 0;
   int unsigned                           shorts = 0;
   int unsigned                           longs = 0;
   int unsigned                           settings_used = 1;
   logic [bdslp_pkg::TimeWidth-1:0]       stamp_ms;
   bit                                    sender_burst = 1'b0;
   bit                                    receiver_burst = 1'b0;
   bit                                    held_off = 1'b0;

   // Directed rows. The first four are read straight off the reset state: the
   // pin idles high (released, active low), a low level that has held for exactly
   // the debounce time is not yet taken, one millisecond later the press fires.
   // The rest walk a long press and its release, a short press, a press across
   // the timestamp wrap with an out-of-order timestamp, a polarity flip that turns
   // a steady high pin into a press, and a zero long-press time with zero debounce.
   stim_row_type stim_table [NumRows] = '{
      '{RowPoll,      1'b1, 32'h0000_0000, 1'b1, 4'b0000},
      '{RowPoll,      1'b0, 32'd10,        1'b1, 4'b0000},
      '{RowPoll,      1'b0, 32'd60,        1'b1, 4'b0000},
      '{RowPoll,      1'b0, 32'd61,        1'b1, 4'b1100},
      '{RowPoll,      1'b1, 32'd100,       1'b0, 4'b0000},
      '{RowPoll,      1'b0, 32'd860,       1'b0, 4'b0000},
      '{RowPoll,      1'b0, 32'd861,       1'b0, 4'b0000},
      '{RowPoll,      1'b1, 32'd2001,      1'b0, 4'b0000},
      '{RowPoll,      1'b1, 32'd2052,      1'b0, 4'b0000},
      '{RowPoll,      1'b0, 32'd3000,      1'b0, 4'b0000},
      '{RowPoll,      1'b0, 32'd3051,      1'b0, 4'b0000},
      '{RowPoll,      1'b1, 32'd3100,      1'b0, 4'b0000},
      '{RowPoll,      1'b1, 32'd3151,      1'b0, 4'b0000},
      '{RowPoll,      1'b0, 32'hFFFF_FFF0, 1'b0, 4'b0000},
      '{RowPoll,      1'b0, 32'h0000_0030, 1'b0, 4'b0000},
      '{RowPoll,      1'b0, 32'hFFFF_FFFF, 1'b0, 4'b0000},
      '{RowPoll,      1'b1, 32'h0000_0100, 1'b0, 4'b0000},
      '{RowPoll,      1'b1, 32'h0000_0200, 1'b0, 4'b0000},
      '{RowActiveLow, 1'b0, 32'd0,         1'b0, 4'b0000},
      '{RowPoll,      1'b1, 32'h0000_0300, 1'b0, 4'b0000},
      '{RowPoll,      1'b1, 32'h0000_0340, 1'b0, 4'b0000},
      '{RowDebounce,  1'b0, 32'd0,         1'b0, 4'b0000},
      '{RowLongPress, 1'b0, 32'd0,         1'b0, 4'b0000},
      '{RowPoll,      1'b1, 32'h0000_0400, 1'b0, 4'b0000},
      '{RowPoll,      1'b0, 32'h0000_0401, 1'b0, 4'b0000},
      '{RowPoll,      1'b0, 32'h0000_0402, 1'b0, 4'b0000},
      '{RowPoll,      1'b1, 32'h0000_0403, 1'b0, 4'b0000},
      '{RowPoll,      1'b1, 32'h0000_0404, 1'b0, 4'b0000},
      '{RowPoll,      1'b0, 32'h0000_0405, 1'b0, 4'b0000},
      '{RowPoll,      1'b0, 32'h7FFF_FFFF, 1'b0, 4'b0000}
   };

   button_debounce_short_long_press dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always #4 clock = ~clock;

   // Works out the flags for one poll and advances the tracked button state.
   // The debounce timer restarts on every change of the active-high reading,
   // and all time differences wrap at 32 bits.
   task automatic debounce_poll(input bdslp_pkg::req_word_type poll,
                                output bdslp_pkg::rsp_word_type flags);
      logic                            reading;
      logic [bdslp_pkg::TimeWidth-1:0] since_change;
      logic [bdslp_pkg::TimeWidth-1:0] held_for;
      reading = set_active_low ? ~poll.pin_level : poll.pin_level;
      flags = '0;
      if (reading != btn_prev_reading) begin
         btn_change_ms = poll.now_ms;
      end
      btn_prev_reading = reading;
      since_change = poll.now_ms - btn_change_ms;
      if (since_change > {16'd0, set_debounce_ms} && reading != btn_state) begin
         btn_state = reading;
         if (btn_state) begin
            btn_press_ms = poll.now_ms;
            btn_long_sent = 1'b0;
            flags.press_event = 1'b1;
         end else begin
            held_for = poll.now_ms - btn_press_ms;
            // A release after a long press gives no short press.
            flags.short_press = !btn_long_sent && held_for < {16'd0, set_long_ms};
         end
      end
      held_for = poll.now_ms - btn_press_ms;
      // With a zero long-press time this fires in the same poll as the press.
      if (btn_state && !btn_long_sent && held_for >= {16'd0, set_long_ms}) begin
         flags.long_press = 1'b1;
         btn_long_sent = 1'b1;
      end
      flags.stable_pressed = btn_state;
   endtask

   // Gap lengths for both sides: mostly none or short, now and then long.
   function automatic int unsigned idle_gap(input bit burst);
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (burst || roll < 6) begin
         return 0;
      end else if (roll < 9) begin
         return $urandom_range(1, 3);
      end else begin
         return $urandom_range(5, 40);
      end
   endfunction

   // Every accepted poll gets its expected flags; every accepted result word is
   // checked against the oldest expectation still waiting.
   always @(posedge clock) begin : scoreboard
      bdslp_pkg::rsp_word_type flags;
      bdslp_pkg::rsp_word_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            debounce_poll(req_payload, flags);
            pending_flags.push_back(want_fixed ? want_word : flags);
            polls_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_flags.size() == 0) begin
               mismatches++;
               if (mismatches <= ShownMismatches) begin
                  $display("unexpected result word %b with nothing outstanding", rsp_payload);
               end
            end else begin
               want = pending_flags.pop_front();
               if (rsp_payload.stable_pressed !== want.stable_pressed ||
                   rsp_payload.press_event !== want.press_event ||
                   rsp_payload.short_press !== want.short_press ||
                   rsp_payload.long_press !== want.long_press) begin
                  mismatches++;
                  if (mismatches <= ShownMismatches) begin
                     $display("result %0d: stable/press/short/long expected %b%b%b%b, got %b%b%b%b",
                              words_checked, want.stable_pressed, want.press_event,
                              want.short_press, want.long_press, rsp_payload.stable_pressed,
                              rsp_payload.press_event, rsp_payload.short_press,
                              rsp_payload.long_press);
                  end
               end
            end
            words_checked++;
            presses += rsp_payload.press_event;
            shorts += rsp_payload.short_press;
            longs += rsp_payload.long_press;
         end
      end
   end

   // Result side. Random stalls, with stretches of none; once, after 200 result
   // words, it holds off long enough for both pipeline registers to fill so that
   // req_ready has to drop while the sender keeps offering polls.
   initial begin : result_sink
      int unsigned stall;
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!held_off && words_checked >= HoldOffAfter) begin
            held_off = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HoldOffCycles) @(posedge clock);
         end
         stall = idle_gap(receiver_burst);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         if ($urandom_range(0, 39) == 0) begin
            receiver_burst = ~receiver_burst;
         end
      end
   end

   // Offers one poll word and returns at the edge where it was accepted. The
   // valid line only drops when a gap follows, so a back-to-back word keeps it
   // high across the edge.
   task automatic send_poll(input logic pin, input logic [bdslp_pkg::TimeWidth-1:0] stamp,
                            input logic fixed, input bdslp_pkg::rsp_word_type want);
      int unsigned gap;
      gap = idle_gap(sender_burst);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{pin_level: pin, now_ms: stamp};
      want_fixed <= fixed;
      want_word <= want;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Waits until every expected word has come back. The first edge lets the
   // scoreboard log the last accepted poll; the wait after the queue empties
   // leaves the block idle before the caller goes on.
   task automatic wait_drained();
      @(posedge clock);
      while (pending_flags.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // One register write (setup and access cycle) followed by a read-back of the
   // same register. The tracked settings change at the edge of the write.
   task automatic csr_write(input logic [bdslp_pkg::CsrIndexWidth-1:0] index,
                            input logic [bdslp_pkg::CsrDataWidth-1:0] value);
      logic [bdslp_pkg::CsrDataWidth-1:0] stored;
      if (index == bdslp_pkg::RegActiveLow) begin
         stored = {31'd0, value[0]};
      end else begin
         stored = {16'd0, value[bdslp_pkg::MsWidth-1:0]};
      end
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (index == bdslp_pkg::RegActiveLow) begin
         set_active_low = value[0];
      end else if (index == bdslp_pkg::RegDebounceMs) begin
         set_debounce_ms = value[bdslp_pkg::MsWidth-1:0];
      end else begin
         set_long_ms = value[bdslp_pkg::MsWidth-1:0];
      end
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== stored) begin
         mismatches++;
         if (mismatches <= ShownMismatches) begin
            $display("register %0d read back %h, expected %h", index, prdata, stored);
         end
      end
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   // Random polls shaped like real button use: contact bounce, a press held for
   // a short or a long time, bounce again and a release, with the time steps
   // scaled to the current settings. About one sequence in eight is replaced by
   // a single poll of line noise with an arbitrary level and timestamp.
   task automatic random_polls(input int unsigned count);
      int unsigned done;
      int unsigned k;
      int unsigned n;
      int unsigned span;
      int unsigned bounce_span;
      logic        level;
      done = 0;
      stamp_ms = $urandom;
      while (done < count) begin
         sender_burst = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 7) == 0) begin
            send_poll(1'($urandom_range(0, 1)), $urandom, 1'b0, '0);
            done++;
         end else begin
            bounce_span = set_debounce_ms / 4 + 1;
            for (k = 0; k < 2; k++) begin
               level = (k == 0) ? ~set_active_low : set_active_low;
               repeat ($urandom_range(0, 4)) begin
                  stamp_ms += $urandom_range(0, bounce_span);
                  send_poll(1'($urandom_range(0, 1)), stamp_ms, 1'b0, '0);
                  done++;
               end
               n = $urandom_range(2, 6);
               span = set_debounce_ms + 1 + n;
               if (k == 1) begin
                  span += $urandom_range(0, 100);
               end else if ($urandom_range(0, 1) == 0) begin
                  span += $urandom_range(0, set_long_ms);
               end else begin
                  span += set_long_ms + $urandom_range(0, 100);
               end
               stamp_ms += $urandom_range(0, 3);
               send_poll(level, stamp_ms, 1'b0, '0);
               done++;
               repeat (n) begin
                  stamp_ms += span / n;
                  send_poll(level, stamp_ms, 1'b0, '0);
                  done++;
               end
            end
         end
      end
      sender_burst = 1'b0;
      req_valid <= 1'b0;
   endtask

   // A new setting of all three registers, written once the block is idle; the
   // button state is deliberately carried over from the previous setting.
   task automatic random_phase(input logic active_low,
                               input logic [bdslp_pkg::MsWidth-1:0] debounce,
                               input logic [bdslp_pkg::MsWidth-1:0] long_ms,
                               input int unsigned count);
      wait_drained();
      csr_write(bdslp_pkg::RegActiveLow, {31'd0, active_low});
      csr_write(bdslp_pkg::RegDebounceMs, {16'd0, debounce});
      csr_write(bdslp_pkg::RegLongPressMs, {16'd0, long_ms});
      settings_used++;
      random_polls(count);
   endtask

   initial begin : run_limit
      repeat (CycleLimit) @(posedge clock);
      $display("[button_debounce_short_long_press] ERROR");
      $finish;
   end

   initial begin : stimulus
      int unsigned i;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_payload <= '0;
      want_fixed <= 1'b0;
      want_word <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < NumRows; i++) begin
         unique case (stim_table[i].kind)
            RowPoll: begin
               send_poll(stim_table[i].pin, stim_table[i].value, stim_table[i].fixed,
                         stim_table[i].want);
            end
            RowActiveLow: begin
               req_valid <= 1'b0;
               wait_drained();
               csr_write(bdslp_pkg::RegActiveLow, stim_table[i].value);
            end
            RowDebounce: begin
               req_valid <= 1'b0;
               wait_drained();
               csr_write(bdslp_pkg::RegDebounceMs, stim_table[i].value);
            end
            default: begin
               req_valid <= 1'b0;
               wait_drained();
               csr_write(bdslp_pkg::RegLongPressMs, stim_table[i].value);
               settings_used++;
            end
         endcase
      end
      req_valid <= 1'b0;

      // Defaults again, then both extremes of the timing registers, a fast
      // setting, and one drawn at random.
      random_phase(bdslp_pkg::ResetActiveLow, bdslp_pkg::ResetDebounceMs,
                   bdslp_pkg::ResetLongPressMs, 140);
      random_phase(1'b0, 16'd0, 16'd0, 80);
      random_phase(1'b1, 16'hFFFF, 16'hFFFF, 60);
      random_phase(1'b0, 16'd3, 16'd40, 150);
      random_phase(1'($urandom_range(0, 1)), 16'($urandom_range(0, 200)),
                   16'($urandom_range(0, 1000)), 120);

      wait_drained();
      repeat (10) @(posedge clock);
      mismatches += pending_flags.size();
      $display("Polled the button %0d times across %0d register settings, %0d result words.",
               polls_taken, settings_used, words_checked);
      $display("Seen: %0d presses, %0d short presses, %0d long presses; %0d mismatches.",
               presses, shorts, longs, mismatches);
      if (mismatches == 0) begin
         $display("[button_debounce_short_long_press] OK");
      end else begin
         $display("[button_debounce_short_long_press] ERROR");
      end
      $finish;
   end

endmodule

// File: button_debounce_short_long_press.f
rtl/core/bdslp_pkg.sv
rtl/core/bdslp_csr.sv
rtl/core/bdslp_core.sv
rtl/core/button_debounce_short_long_press.sv
sim/tb.sv
